// ===== sv/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg: shared definitions for the multi-LED blink controller
// Sizes, command codes, table entry layout, result record and color palette.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

  localparam int LED_COUNT = 8;
  localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // command codes
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_SET       = 3'd1;
  localparam logic [2:0] ACT_SET_ALL   = 3'd2;
  localparam logic [2:0] ACT_BLINK     = 3'd3;
  localparam logic [2:0] ACT_STOP      = 3'd4;
  localparam logic [2:0] ACT_BLINK_ALL = 3'd5;
  localparam logic [2:0] ACT_STOP_ALL  = 3'd6;

  // palette codes
  localparam logic [2:0] PAL_OFF    = 3'd0;
  localparam logic [2:0] PAL_GREEN  = 3'd1;
  localparam logic [2:0] PAL_RED    = 3'd2;
  localparam logic [2:0] PAL_BLUE   = 3'd3;
  localparam logic [2:0] PAL_ORANGE = 3'd4;
  localparam logic [2:0] PAL_WHITE  = 3'd5;
  localparam logic [2:0] PAL_PURPLE = 3'd6;
  localparam logic [2:0] PAL_YELLOW = 3'd7;

  typedef logic [IDX_W-1:0] idx_t;

  // one LED's blink record in the table memory
  typedef struct packed {
    logic        phase;
    logic [2:0]  on_code;
    logic [2:0]  off_code;
    logic [31:0] period;
    logic [31:0] last_time;
  } entry_t;

  // color update from the sequencer to the output stage
  typedef struct packed {
    logic       valid;
    logic [3:0] led;
    logic [2:0] code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic rgb_t pal_rgb(input logic [2:0] code);
    rgb_t c;
    case (code)
      PAL_OFF:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
      PAL_GREEN:  c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
      PAL_RED:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      PAL_BLUE:   c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      PAL_ORANGE: c = '{red: 8'd255, green: 8'd80,  blue: 8'd0};
      PAL_WHITE:  c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
      PAL_PURPLE: c = '{red: 8'd150, green: 8'd0,   blue: 8'd150};
      default:    c = '{red: 8'd255, green: 8'd200, blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lbc_ram.sv =====
// ----------------------------------------------------------------------------
// lbc_ram: LED blink table
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ram (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire lbc_pkg::idx_t   wr_addr,
  input  wire lbc_pkg::entry_t wr_data,
  input  wire lbc_pkg::idx_t   rd_addr,
  output lbc_pkg::entry_t      rd_data
);
  import lbc_pkg::*;

  entry_t mem [LED_COUNT];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/lbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbc_ctrl: command sequencer and blink walker
// Decodes commands, walks the LED table for ticks (read, then check and
// write back), and orders color updates so the final one carries last.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [2:0]      in_action,
  input  wire logic [3:0]      in_led_index,
  input  wire logic [2:0]      in_color_on,
  input  wire logic [2:0]      in_color_off,
  input  wire logic [31:0]     in_interval_ms,
  output logic                 busy,
  output logic                 ram_we,
  output lbc_pkg::idx_t        ram_wr_addr,
  output lbc_pkg::entry_t      ram_wr_data,
  output lbc_pkg::idx_t        ram_rd_addr,
  input  wire lbc_pkg::entry_t ram_rd_data,
  output lbc_pkg::res_t        res
);
  import lbc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TRD   = 3'd1;
  localparam logic [2:0] S_TCHK  = 3'd2;
  localparam logic [2:0] S_ALL   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]           state_r, state_nxt;
  idx_t                 cnt_r, cnt_nxt;
  logic [2:0]           act_r, act_nxt;
  logic [2:0]           con_r, con_nxt;
  logic [2:0]           coff_r, coff_nxt;
  logic [31:0]          iv_r, iv_nxt;
  logic [31:0]          time_r, time_nxt;
  logic [LED_COUNT-1:0] active_r, active_nxt;
  res_t                 pend_r, pend_nxt;
  res_t                 res_r, res_nxt;

  logic       accept;
  logic       in_range;
  idx_t       in_idx;
  logic       push_en;
  logic [3:0] push_led;
  logic [2:0] push_code;
  logic [31:0] elapsed;
  logic       hit;
  logic       cnt_end;

  assign accept   = start && (state_r == S_IDLE);
  assign in_range = {1'b0, in_led_index} < 5'(LED_COUNT);
  assign in_idx   = in_led_index[IDX_W-1:0];
  assign cnt_end  = (cnt_r == IDX_W'(LED_COUNT - 1));

  // wrapped elapsed time against the LED's interval
  assign elapsed = time_r - ram_rd_data.last_time;
  assign hit     = active_r[cnt_r] && (elapsed >= ram_rd_data.period);

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    act_nxt     = act_r;
    con_nxt     = con_r;
    coff_nxt    = coff_r;
    iv_nxt      = iv_r;
    time_nxt    = time_r;
    active_nxt  = active_r;
    pend_nxt    = pend_r;
    res_nxt     = '0;
    ram_we      = 1'b0;
    ram_wr_addr = cnt_r;
    ram_wr_data = '{phase: 1'b1, on_code: con_r, off_code: coff_r,
                    period: iv_r, last_time: time_r};
    ram_rd_addr = cnt_r;
    push_en     = 1'b0;
    push_led    = 4'(cnt_r);
    push_code   = con_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt  = in_action;
          con_nxt  = in_color_on;
          coff_nxt = in_color_off;
          iv_nxt   = in_interval_ms;
          cnt_nxt  = '0;
          unique case (in_action) inside
            ACT_TICK: begin
              time_nxt  = time_r + 32'd1;
              state_nxt = S_TRD;
            end
            ACT_SET, ACT_STOP: begin
              if (in_range) begin
                active_nxt[in_idx] = 1'b0;
                push_en   = 1'b1;
                push_led  = in_led_index;
                push_code = in_color_on;
                state_nxt = S_FLUSH;
              end
            end
            ACT_BLINK: begin
              if (in_range) begin
                active_nxt[in_idx] = 1'b1;
                ram_we      = 1'b1;
                ram_wr_addr = in_idx;
                ram_wr_data = '{phase: 1'b1, on_code: in_color_on,
                                off_code: in_color_off, period: in_interval_ms,
                                last_time: time_r};
                push_en   = 1'b1;
                push_led  = in_led_index;
                push_code = in_color_on;
                state_nxt = S_FLUSH;
              end
            end
            ACT_SET_ALL, ACT_BLINK_ALL, ACT_STOP_ALL: begin
              state_nxt = S_ALL;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // issue the table read for LED cnt_r
      S_TRD: begin
        state_nxt = S_TCHK;
      end

      // check elapsed time, toggle and write back
      S_TCHK: begin
        if (hit) begin
          ram_we      = 1'b1;
          ram_wr_data = '{phase: ~ram_rd_data.phase,
                          on_code: ram_rd_data.on_code,
                          off_code: ram_rd_data.off_code,
                          period: ram_rd_data.period,
                          last_time: time_r};
          push_en   = 1'b1;
          push_code = ram_rd_data.phase ? ram_rd_data.off_code
                                        : ram_rd_data.on_code;
        end
        if (cnt_end) begin
          state_nxt = S_FLUSH;
        end else begin
          cnt_nxt   = cnt_r + IDX_W'(1);
          state_nxt = S_TRD;
        end
      end

      // all-LED commands, one LED per cycle
      S_ALL: begin
        active_nxt[cnt_r] = (act_r == ACT_BLINK_ALL);
        ram_we  = (act_r == ACT_BLINK_ALL);
        push_en = 1'b1;
        if (cnt_end) begin
          state_nxt = S_FLUSH;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end

      // send the held update as the final one of the run
      S_FLUSH: begin
        if (pend_r.valid) begin
          res_nxt      = pend_r;
          res_nxt.last = 1'b1;
        end
        pend_nxt  = '0;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // one-deep hold: a new update releases the previous one as not last
    if (push_en) begin
      res_nxt      = pend_r;
      res_nxt.last = 1'b0;
      pend_nxt     = '{valid: 1'b1, led: push_led, code: push_code, last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      time_r   <= '0;
      active_r <= '0;
      pend_r   <= '0;
      res_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      time_r   <= time_nxt;
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      res_r    <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    act_r  <= act_nxt;
    con_r  <= con_nxt;
    coff_r <= coff_nxt;
    iv_r   <= iv_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/multi_led_blink_controller_core.sv =====
// ----------------------------------------------------------------------------
// multi_led_blink_controller_core: status LED table with blinking
// Tick: accept, a table read and a check per LED, then flush; all-LED commands
// visit each LED in turn, then flush; single-LED ones accept, then flush;
// ignored ones end at accept. Busy is high for every cycle of an item but the
// accept cycle. No stall input: each update is held until the next one or the
// flush, and the flush sends the last of a run via the result and output registers.
// Synchronous active-low reset clears time, blink flags and the output strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_led_blink_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [3:0]  in_led_index,
  input  wire logic [2:0]  in_color_on,
  input  wire logic [2:0]  in_color_off,
  input  wire logic [31:0] in_interval_ms,
  output logic             out_valid,
  output logic [3:0]       out_led,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last
);
  import lbc_pkg::*;

  logic   ram_we;
  idx_t   ram_wr_addr;
  entry_t ram_wr_data;
  idx_t   ram_rd_addr;
  entry_t ram_rd_data;
  res_t   res;
  rgb_t   rgb;

  logic       out_valid_r;
  logic [3:0] out_led_r;
  rgb_t       out_rgb_r;
  logic       out_last_r;

  lbc_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lbc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_action      (in_action),
    .in_led_index   (in_led_index),
    .in_color_on    (in_color_on),
    .in_color_off   (in_color_off),
    .in_interval_ms (in_interval_ms),
    .busy           (busy),
    .ram_we         (ram_we),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_addr    (ram_rd_addr),
    .ram_rd_data    (ram_rd_data),
    .res            (res)
  );

  // palette lookup
  assign rgb = pal_rgb(res.code);

  // output register: one transfer per strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_led_r  <= res.led;
    out_rgb_r  <= rgb;
    out_last_r <= res.last;
  end

  assign out_valid = out_valid_r;
  assign out_led   = out_led_r;
  assign out_red   = out_rgb_r.red;
  assign out_green = out_rgb_r.green;
  assign out_blue  = out_rgb_r.blue;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== verif/tb_multi_led_blink_controller_core.sv =====
// ----------------------------------------------------------------------------
// tb_multi_led_blink_controller_core: self-checking bench for the LED blinker
// A directed table (extremes, every command, index and code corner cases) is
// followed by random traffic that is mostly ticks over a few blinking LEDs.
// Every color update leaving the block is matched, field by field and in order,
// against a cycle-free behavioral LED table predictor or a row's typed update.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_led_blink_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lbc_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 5;
  localparam int          RANDOM_ITEMS = 305;
  localparam int          DRAIN_CYCLES = 2 * LED_COUNT + 24;
  localparam int          DIR_ROWS     = 25;
  localparam logic [2:0]  ACT_UNUSED   = 3'd7;
  localparam logic [31:0] IV_MAX       = 32'hFFFF_FFFF;

  typedef struct {
    logic [2:0]  action;
    logic [3:0]  led_index;
    logic [2:0]  color_on;
    logic [2:0]  color_off;
    logic [31:0] interval_ms;
  } blink_cmd_t;

  typedef struct {
    logic [3:0] led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } led_update_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // predictor decides
    CHK_NONE,    // no update at all
    CHK_ONE      // exactly the single update typed in the row
  } chk_kind_t;

  typedef struct {
    logic [2:0]  action;
    logic [3:0]  led_index;
    logic [2:0]  color_on;
    logic [2:0]  color_off;
    logic [31:0] interval_ms;
    chk_kind_t   kind;
    logic [3:0]  led;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } dir_row_t;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ACT_TICK,      4'd0,  PAL_OFF,    PAL_OFF,    32'd0,  CHK_NONE,  4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_SET,       4'd0,  PAL_RED,    PAL_YELLOW, IV_MAX, CHK_ONE,   4'd0, 8'd255, 8'd0,   8'd0},
    '{ACT_SET,       4'd8,  PAL_GREEN,  PAL_OFF,    32'd0,  CHK_NONE,  4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_SET,       4'd15, PAL_WHITE,  PAL_WHITE,  IV_MAX, CHK_NONE,  4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_UNUSED,    4'd2,  PAL_YELLOW, PAL_YELLOW, IV_MAX, CHK_NONE,  4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_SET,       4'd7,  PAL_YELLOW, PAL_OFF,    32'd0,  CHK_ONE,   4'd7, 8'd255, 8'd200, 8'd0},
    '{ACT_SET_ALL,   4'd9,  PAL_WHITE,  PAL_RED,    32'd3,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_BLINK,     4'd3,  PAL_GREEN,  PAL_PURPLE, 32'd0,  CHK_ONE,   4'd3, 8'd0,   8'd255, 8'd0},
    '{ACT_TICK,      4'd15, PAL_YELLOW, PAL_YELLOW, IV_MAX, CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_TICK,      4'd0,  PAL_OFF,    PAL_OFF,    32'd0,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_BLINK,     4'd5,  PAL_ORANGE, PAL_BLUE,   32'd2,  CHK_ONE,   4'd5, 8'd255, 8'd80,  8'd0},
    '{ACT_TICK,      4'd0,  PAL_OFF,    PAL_OFF,    32'd0,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_TICK,      4'd0,  PAL_OFF,    PAL_OFF,    32'd0,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_TICK,      4'd0,  PAL_OFF,    PAL_OFF,    32'd0,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_BLINK,     4'd12, PAL_RED,    PAL_GREEN,  32'd0,  CHK_NONE,  4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_STOP,      4'd14, PAL_RED,    PAL_GREEN,  32'd0,  CHK_NONE,  4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_STOP,      4'd3,  PAL_BLUE,   PAL_WHITE,  IV_MAX, CHK_ONE,   4'd3, 8'd0,   8'd0,   8'd255},
    '{ACT_BLINK_ALL, 4'd11, PAL_YELLOW, PAL_OFF,    32'd1,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_TICK,      4'd0,  PAL_OFF,    PAL_OFF,    32'd0,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_TICK,      4'd0,  PAL_OFF,    PAL_OFF,    32'd0,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_BLINK,     4'd0,  PAL_RED,    PAL_WHITE,  IV_MAX, CHK_ONE,   4'd0, 8'd255, 8'd0,   8'd0},
    '{ACT_TICK,      4'd0,  PAL_OFF,    PAL_OFF,    32'd0,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_STOP_ALL,  4'd6,  PAL_PURPLE, PAL_GREEN,  32'd7,  CHK_MODEL, 4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_TICK,      4'd0,  PAL_OFF,    PAL_OFF,    32'd0,  CHK_NONE,  4'd0, 8'd0,   8'd0,   8'd0},
    '{ACT_SET,       4'd1,  PAL_OFF,    PAL_YELLOW, IV_MAX, CHK_ONE,   4'd1, 8'd0,   8'd0,   8'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_action;
  logic [3:0]  in_led_index;
  logic [2:0]  in_color_on;
  logic [2:0]  in_color_off;
  logic [31:0] in_interval_ms;
  logic        out_valid;
  logic [3:0]  out_led;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_last;

  // predictor copy of the LED table
  logic        led_blinking  [LED_COUNT];
  logic        led_phase     [LED_COUNT];
  logic [2:0]  led_on_code   [LED_COUNT];
  logic [2:0]  led_off_code  [LED_COUNT];
  logic [31:0] led_period    [LED_COUNT];
  logic [31:0] led_toggled_at[LED_COUNT];
  logic [31:0] now_ms;

  led_update_t led_updates_due[$];
  int          err_count  = 0;
  int          burst_left = 0;

  multi_led_blink_controller_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_led_index   (in_led_index),
    .in_color_on    (in_color_on),
    .in_color_off   (in_color_off),
    .in_interval_ms (in_interval_ms),
    .out_valid      (out_valid),
    .out_led        (out_led),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_last       (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // palette lookup, tagged with the LED it belongs to
  function automatic led_update_t color_update(input int led, input logic [2:0] code);
    led_update_t u;
    u.led  = 4'(led);
    u.last = 1'b0;
    case (code)
      PAL_OFF:    {u.red, u.green, u.blue} = {8'd0,   8'd0,   8'd0};
      PAL_GREEN:  {u.red, u.green, u.blue} = {8'd0,   8'd255, 8'd0};
      PAL_RED:    {u.red, u.green, u.blue} = {8'd255, 8'd0,   8'd0};
      PAL_BLUE:   {u.red, u.green, u.blue} = {8'd0,   8'd0,   8'd255};
      PAL_ORANGE: {u.red, u.green, u.blue} = {8'd255, 8'd80,  8'd0};
      PAL_WHITE:  {u.red, u.green, u.blue} = {8'd255, 8'd255, 8'd255};
      PAL_PURPLE: {u.red, u.green, u.blue} = {8'd150, 8'd0,   8'd150};
      default:    {u.red, u.green, u.blue} = {8'd255, 8'd200, 8'd0};
    endcase
    return u;
  endfunction

  function automatic void arm_blink(input int i, input blink_cmd_t c);
    led_blinking[i]   = 1'b1;
    led_phase[i]      = 1'b1;
    led_on_code[i]    = c.color_on;
    led_off_code[i]   = c.color_off;
    led_period[i]     = c.interval_ms;
    led_toggled_at[i] = now_ms;
  endfunction

  function automatic bit is_ignored(input blink_cmd_t c);
    bit single;
    single = (c.action == ACT_SET) || (c.action == ACT_BLINK) || (c.action == ACT_STOP);
    return (c.action == ACT_UNUSED) || (single && c.led_index >= LED_COUNT);
  endfunction

  // apply one command to the table and list the color updates it causes
  function automatic void predict_updates(input blink_cmd_t c, ref led_update_t upd[$]);
    logic [31:0] elapsed;
    upd.delete();
    if (is_ignored(c)) return;
    case (c.action)
      ACT_TICK: begin
        now_ms = now_ms + 32'd1;
        for (int i = 0; i < LED_COUNT; i++) begin
          elapsed = now_ms - led_toggled_at[i];
          if (led_blinking[i] && elapsed >= led_period[i]) begin
            led_phase[i]      = ~led_phase[i];
            led_toggled_at[i] = now_ms;
            upd.push_back(color_update(i, led_phase[i] ? led_on_code[i] : led_off_code[i]));
          end
        end
      end
      ACT_SET, ACT_STOP: begin
        led_blinking[c.led_index] = 1'b0;
        upd.push_back(color_update(c.led_index, c.color_on));
      end
      ACT_SET_ALL, ACT_STOP_ALL: begin
        for (int i = 0; i < LED_COUNT; i++) begin
          led_blinking[i] = 1'b0;
          upd.push_back(color_update(i, c.color_on));
        end
      end
      ACT_BLINK: begin
        arm_blink(c.led_index, c);
        upd.push_back(color_update(c.led_index, c.color_on));
      end
      ACT_BLINK_ALL: begin
        for (int i = 0; i < LED_COUNT; i++) begin
          arm_blink(i, c);
          upd.push_back(color_update(i, c.color_on));
        end
      end
      default: ;
    endcase
    if (upd.size() > 0) upd[upd.size() - 1].last = 1'b1;
  endfunction

  // sender gap: mostly none or short, a few long, with gap-free bursts
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic blink_cmd_t random_cmd();
    blink_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 52)      c.action = ACT_TICK;
    else if (r < 62) c.action = ACT_BLINK;
    else if (r < 66) c.action = ACT_BLINK_ALL;
    else if (r < 74) c.action = ACT_STOP;
    else if (r < 82) c.action = ACT_SET;
    else if (r < 86) c.action = ACT_SET_ALL;
    else if (r < 90) c.action = ACT_STOP_ALL;
    else if (r < 94) c.action = ACT_UNUSED;
    else             c.action = ACT_TICK;
    if ($urandom_range(0, 99) < 82) c.led_index = 4'($urandom_range(0, LED_COUNT - 1));
    else                            c.led_index = 4'($urandom_range(LED_COUNT, 15));
    c.color_on  = 3'($urandom_range(0, 7));
    c.color_off = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    // short intervals keep LEDs toggling; full-range values cover every bit
    if (r < 70)      c.interval_ms = $urandom_range(0, 4);
    else if (r < 85) c.interval_ms = $urandom_range(5, 20);
    else             c.interval_ms = $urandom();
    return c;
  endfunction

  // one command transfer; expectations are queued at the accepting edge
  task automatic send_cmd(input blink_cmd_t c, input chk_kind_t kind,
                          input led_update_t typed);
    int gap;
    led_update_t upd[$];
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_action      <= c.action;
    in_led_index   <= c.led_index;
    in_color_on    <= c.color_on;
    in_color_off   <= c.color_off;
    in_interval_ms <= c.interval_ms;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_updates(c, upd);
    case (kind)
      CHK_MODEL: foreach (upd[k]) led_updates_due.push_back(upd[k]);
      CHK_ONE:   led_updates_due.push_back(typed);
      default:   ;
    endcase
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin : update_monitor
    led_update_t exp_u;
    if (rst_n && out_valid) begin
      if (led_updates_due.size() == 0) begin
        $error("unexpected color update for LED %0d", out_led);
        err_count++;
      end else begin
        exp_u = led_updates_due.pop_front();
        check_field("out_led",   exp_u.led,   out_led);
        check_field("out_red",   exp_u.red,   out_red);
        check_field("out_green", exp_u.green, out_green);
        check_field("out_blue",  exp_u.blue,  out_blue);
        check_field("out_last",  exp_u.last,  out_last);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    blink_cmd_t  c;
    led_update_t typed;
    int          counted;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = ACT_TICK;
    in_led_index   = 4'd0;
    in_color_on    = PAL_OFF;
    in_color_off   = PAL_OFF;
    in_interval_ms = 32'd0;
    now_ms         = 32'd0;
    for (int i = 0; i < LED_COUNT; i++) begin
      led_blinking[i]   = 1'b0;
      led_phase[i]      = 1'b0;
      led_on_code[i]    = PAL_OFF;
      led_off_code[i]   = PAL_OFF;
      led_period[i]     = 32'd0;
      led_toggled_at[i] = 32'd0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[r]) begin
      c.action      = directed_rows[r].action;
      c.led_index   = directed_rows[r].led_index;
      c.color_on    = directed_rows[r].color_on;
      c.color_off   = directed_rows[r].color_off;
      c.interval_ms = directed_rows[r].interval_ms;
      typed.led     = directed_rows[r].led;
      typed.red     = directed_rows[r].red;
      typed.green   = directed_rows[r].green;
      typed.blue    = directed_rows[r].blue;
      typed.last    = 1'b1;
      send_cmd(c, directed_rows[r].kind, typed);
    end

    // random traffic
    typed   = '{default: '0};
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      c = random_cmd();
      send_cmd(c, CHK_MODEL, typed);
      counted++;
    end

    // drain
    start <= 1'b0;
    while (led_updates_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (led_updates_due.size() != 0) begin
      $error("%0d expected color updates never arrived", led_updates_due.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000 * 1ns);
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
